@@ rtl/core/onb_pkg.sv @@
// ----------------------------------------------------------------------------
// Oren-Nayar BRDF evaluator package
// Shared constants for the Oren-Nayar diffuse evaluation pipeline.
// ----------------------------------------------------------------------------
package onb_pkg;

	localparam int FRAC_BITS_DEF = 15;
	localparam int INVPI_W = 23;
	localparam logic [INVPI_W-1:0] INVPI_Q24 = 23'd5340354;

endpackage

@@ rtl/core/oren_nayar_brdf_eval.sv @@
// ----------------------------------------------------------------------------
// Oren-Nayar BRDF evaluator
// Evaluates the qualitative Oren-Nayar diffuse lobe and its cosine pdf.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one result word per input
// word, in order. Most of its pipeline depth lies in the restoring divider
// for the azimuth term, which resolves one quotient bit per stage, and in
// the A and B dividers ahead of it. When a valid output word is stalled the
// whole pipeline holds.
module oren_nayar_brdf_eval #(
	parameter int FRAC_BITS = onb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] in_dir_x,
	input  logic signed [15:0] in_dir_y,
	input  logic signed [15:0] in_dir_z,
	input  logic signed [15:0] out_dir_x,
	input  logic signed [15:0] out_dir_y,
	input  logic signed [15:0] out_dir_z,
	input  logic [14:0]        roughness,
	input  logic [15:0]        albedo_red,
	input  logic [15:0]        albedo_green,
	input  logic [15:0]        albedo_blue,
	input  logic               lane_active,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        value_red,
	output logic [15:0]        value_green,
	output logic [15:0]        value_blue,
	output logic [15:0]        density,
	output logic               valid_res
);

	localparam int F    = FRAC_BITS;
	localparam int S2W  = F - 1;
	localparam int NAW  = 2 * F - 1;
	localparam int DAW  = F + 1;
	localparam int NBW  = 2 * F - 2;
	localparam int DBW  = F;
	localparam int QAW  = F - 1;
	localparam int DOTW = 17;
	localparam int CSW  = 15;
	localparam int P1W  = QAW + DOTW;
	localparam int PAW  = F + 1 + CSW;
	localparam int NCW  = P1W + CSW;
	localparam int QCW  = P1W;
	localparam int SMW  = PAW + 1;
	localparam int S16W = SMW - (F - 1);
	localparam int ALW  = 48;
	localparam int MW   = 16 + S16W;
	localparam int IPW  = onb_pkg::INVPI_W;
	localparam int VW   = MW + IPW;
	localparam int DNW  = CSW + IPW;
	localparam int SAW  = DOTW + CSW;
	localparam int SBW  = CSW + ALW + 1;
	localparam int SCW  = PAW + ALW + 1 + CSW;

	localparam logic [F-1:0]   C033 = F'(((33 << F) + 50) / 100);
	localparam logic [F-1:0]   C009 = F'(((9 << F) + 50) / 100);
	localparam logic [S2W-1:0] C045 = S2W'(((45 << F) + 50) / 100);
	localparam logic [F:0]     ONE  = (F + 1)'(1) << F;

	logic adv;
	logic enable_q;

	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	// Stage 1: products of the inputs.
	logic [F+14:0]       a_wide;
	logic                vld_s1;
	logic                ok_s1;
	logic [2*F-1:0]      aa_s1;
	logic signed [31:0]  pxx_s1;
	logic signed [31:0]  pyy_s1;
	logic [CSW-1:0]      zi_s1;
	logic [CSW-1:0]      zo_s1;
	logic [ALW-1:0]      alb_s1;

	assign a_wide = {roughness, F'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1  <= enable_q && lane_active && !in_dir_z[15] && (in_dir_z != '0)
				&& !out_dir_z[15] && (out_dir_z != '0);
			aa_s1  <= (2 * F)'(a_wide[F+14:15]) * (2 * F)'(a_wide[F+14:15]);
			pxx_s1 <= in_dir_x * out_dir_x;
			pyy_s1 <= in_dir_y * out_dir_y;
			zi_s1  <= in_dir_z[14:0];
			zo_s1  <= out_dir_z[14:0];
			alb_s1 <= {albedo_red, albedo_green, albedo_blue};
		end
	end

	// Stage 2: sigma squared, divider operands and the in-plane dot product.
	logic [S2W-1:0]     s2_w;
	logic signed [32:0] dot_w;
	logic               vld_s2;
	logic               ok_s2;
	logic [NAW-1:0]     na_s2;
	logic [DAW-1:0]     da_s2;
	logic [NBW-1:0]     nb_s2;
	logic [DBW-1:0]     db_s2;
	logic [DOTW-1:0]    dot15_s2;
	logic [CSW-1:0]     zo_s2;
	logic [CSW-1:0]     cmax_s2;
	logic [ALW-1:0]     alb_s2;

	assign s2_w  = aa_s1[2*F-1:F+1];
	assign dot_w = 33'(pxx_s1) + 33'(pyy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s2    <= ok_s1;
			na_s2    <= {s2_w, F'(0)};
			da_s2    <= {F'(s2_w) + C033, 1'b0};
			nb_s2    <= NBW'(s2_w) * NBW'(C045);
			db_s2    <= F'(s2_w) + C009;
			dot15_s2 <= (!dot_w[32] && dot_w != '0) ? dot_w[31:15] : '0;
			zo_s2    <= zo_s1;
			cmax_s2  <= (zi_s1 > zo_s1) ? zi_s1 : zo_s1;
			alb_s2   <= alb_s1;
		end
	end

	// A and B terms.
	logic           vld_da;
	logic           vld_db;
	logic [QAW-1:0] qa;
	logic [QAW-1:0] qb;
	logic [SAW-1:0] side_a;
	logic [SBW-1:0] side_b;

	onb_div #(.NW(NAW), .DW(DAW), .QW(QAW), .SW(SAW)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s2),
		.num      (na_s2),
		.den      (da_s2),
		.side_in  ({dot15_s2, zo_s2}),
		.vld_out  (vld_da),
		.quo      (qa),
		.side_out (side_a)
	);

	onb_div #(.NW(NBW), .DW(DBW), .QW(QAW), .SW(SBW)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s2),
		.num      (nb_s2),
		.den      (db_s2),
		.side_in  ({cmax_s2, alb_s2, ok_s2}),
		.vld_out  (vld_db),
		.quo      (qb),
		.side_out (side_b)
	);

	// Stage 3: A*cos_o and B*dot.
	logic [F:0]      a_term;
	logic [DOTW-1:0] dot15_d;
	logic [CSW-1:0]  zo_d;
	logic [CSW-1:0]  cmax_d;
	logic [ALW-1:0]  alb_d;
	logic            ok_d;
	logic            vld_s3;
	logic            ok_s3;
	logic [P1W-1:0]  p1_s3;
	logic [PAW-1:0]  pa_s3;
	logic [CSW-1:0]  zo_s3;
	logic [CSW-1:0]  cmax_s3;
	logic [ALW-1:0]  alb_s3;

	assign {dot15_d, zo_d}       = side_a;
	assign {cmax_d, alb_d, ok_d} = side_b;
	assign a_term                = ONE - (F + 1)'(qa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_da && vld_db;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3   <= ok_d;
			p1_s3   <= P1W'(qb) * P1W'(dot15_d);
			pa_s3   <= PAW'(a_term) * PAW'(zo_d);
			zo_s3   <= zo_d;
			cmax_s3 <= cmax_d;
			alb_s3  <= alb_d;
		end
	end

	// Stage 4: numerator of the azimuth term.
	logic           vld_s4;
	logic           ok_s4;
	logic [NCW-1:0] nc_s4;
	logic [PAW-1:0] pa_s4;
	logic [CSW-1:0] zo_s4;
	logic [CSW-1:0] cmax_s4;
	logic [ALW-1:0] alb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s4   <= ok_s3;
			nc_s4   <= NCW'(p1_s3) * NCW'(zo_s3);
			pa_s4   <= pa_s3;
			zo_s4   <= zo_s3;
			cmax_s4 <= cmax_s3;
			alb_s4  <= alb_s3;
		end
	end

	logic           vld_dc;
	logic [QCW-1:0] qc;
	logic [SCW-1:0] side_c;
	logic [PAW-1:0] pa_d;
	logic [ALW-1:0] alb_c;
	logic           ok_c;
	logic [CSW-1:0] zo_c;

	onb_div #(.NW(NCW), .DW(CSW), .QW(QCW), .SW(SCW)) u_div_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s4),
		.num      (nc_s4),
		.den      (cmax_s4),
		.side_in  ({pa_s4, alb_s4, ok_s4, zo_s4}),
		.vld_out  (vld_dc),
		.quo      (qc),
		.side_out (side_c)
	);

	assign {pa_d, alb_c, ok_c, zo_c} = side_c;

	// Stage 5: scaled sum.
	logic [SMW-1:0]  sum_w;
	logic            vld_s5;
	logic            ok_s5;
	logic [S16W-1:0] s16_s5;
	logic [CSW-1:0]  zo_s5;
	logic [ALW-1:0]  alb_s5;

	assign sum_w = SMW'(pa_d) + SMW'(qc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_dc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s5  <= ok_c;
			s16_s5 <= sum_w[SMW-1:F-1];
			zo_s5  <= zo_c;
			alb_s5 <= alb_c;
		end
	end

	// Stage 6: albedo products.
	logic           vld_s6;
	logic           ok_s6;
	logic [MW-1:0]  mr_s6;
	logic [MW-1:0]  mg_s6;
	logic [MW-1:0]  mb_s6;
	logic [CSW-1:0] zo_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s6 <= ok_s5;
			mr_s6 <= MW'(alb_s5[47:32]) * MW'(s16_s5);
			mg_s6 <= MW'(alb_s5[31:16]) * MW'(s16_s5);
			mb_s6 <= MW'(alb_s5[15:0]) * MW'(s16_s5);
			zo_s6 <= zo_s5;
		end
	end

	// Output stage: scale by 1/pi and saturate.
	logic [VW-1:0]  vr_w;
	logic [VW-1:0]  vg_w;
	logic [VW-1:0]  vb_w;
	logic [DNW-1:0] dn_w;

	assign vr_w = VW'(mr_s6) * VW'(onb_pkg::INVPI_Q24);
	assign vg_w = VW'(mg_s6) * VW'(onb_pkg::INVPI_Q24);
	assign vb_w = VW'(mb_s6) * VW'(onb_pkg::INVPI_Q24);
	assign dn_w = DNW'(zo_s6) * DNW'(onb_pkg::INVPI_Q24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			valid_res   <= ok_s6;
			value_red   <= !ok_s6 ? '0 : (vr_w[VW-1:56] != '0) ? 16'hFFFF : vr_w[55:40];
			value_green <= !ok_s6 ? '0 : (vg_w[VW-1:56] != '0) ? 16'hFFFF : vg_w[55:40];
			value_blue  <= !ok_s6 ? '0 : (vb_w[VW-1:56] != '0) ? 16'hFFFF : vb_w[55:40];
			density     <= !ok_s6 ? '0 : 16'(dn_w[DNW-1:23]);
		end
	end

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		vld_da == vld_db)
		else $error("A and B dividers out of step");

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> (value_red == '0 && value_green == '0
			&& value_blue == '0 && density == '0))
		else $error("Nonzero result on an invalid word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("Input stalled without a held output word");

endmodule

@@ rtl/core/onb_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned divider that resolves one quotient bit per register stage and
// carries a sideband word alongside each division.
// ----------------------------------------------------------------------------
module onb_div #(
	parameter int NW = 29,
	parameter int DW = 16,
	parameter int QW = 14,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int CW = NW + DW;

	logic [NW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic          vld_s  [0:QW];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int BIT = QW - 1 - k;
		logic [CW-1:0] rem_x;
		logic [CW-1:0] sub_x;
		logic [CW-1:0] dif_x;
		logic          ge;

		assign rem_x = CW'(rem_s[k]);
		assign sub_x = CW'(den_s[k]) << BIT;
		assign ge    = rem_x >= sub_x;
		assign dif_x = rem_x - sub_x;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? dif_x[NW-1:0] : rem_s[k];
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= (quo_s[k] << 1) | QW'(ge);
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld_out  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

@@ tb/tb_oren_nayar_brdf_eval.sv @@
// ----------------------------------------------------------------------------
// Oren-Nayar BRDF evaluator testbench
// Drives shading words through the evaluator with random idling on both
// sides, predicts each result in a scoreboard class and compares every field.
// ----------------------------------------------------------------------------
module tb_oren_nayar_brdf_eval;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = onb_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = 2 * FB + 22;
	localparam int WATCHDOG = 4000;

	typedef struct packed {
		logic signed [15:0] ix, iy, iz, ox, oy, oz;
		logic [14:0] rough;
		logic [15:0] ar, ag, ab;
		logic lane;
	} shade_t;

	typedef struct packed {
		logic [15:0] vr, vg, vb, dens;
		logic vres;
	} brdf_t;

	class brdf_scoreboard;
		brdf_t pending[$];
		bit lobe_on = 1'b1;
		int mismatches = 0;
		int checked = 0;

		function brdf_t evaluate(shade_t s);
			brdf_t r;
			longint unsigned one, a, s2, c033, c009, c045, da, db, ka, kb;
			longint unsigned cos_o, cos_max, dot15, sum, s16, prod;
			longint unsigned alb[3];
			longint dot;
			r = '0;
			if (!lobe_on || !s.lane || s.iz <= 0 || s.oz <= 0)
				return r;
			one = 64'd1 << FB;
			a = (FB >= 15) ? (64'(s.rough) << (FB - 15)) : (64'(s.rough) >> (15 - FB));
			s2 = (a * a) >> (FB + 1);
			c033 = ((64'd33 << FB) + 50) / 100;
			c009 = ((64'd9 << FB) + 50) / 100;
			c045 = ((64'd45 << FB) + 50) / 100;
			da = 2 * (s2 + c033);
			db = s2 + c009;
			if (da == 0) da = 1;
			if (db == 0) db = 1;
			ka = one - ((s2 << FB) / da);
			kb = (s2 * c045) / db;
			cos_o = 64'(s.oz);
			cos_max = (s.iz > s.oz) ? 64'(s.iz) : 64'(s.oz);
			dot = longint'(s.ix) * longint'(s.ox) + longint'(s.iy) * longint'(s.oy);
			dot15 = (dot > 0) ? (64'(dot) >> 15) : 64'd0;
			sum = ka * cos_o + (kb * dot15 * cos_o) / cos_max;
			s16 = sum >> (FB - 1);
			alb[0] = 64'(s.ar); alb[1] = 64'(s.ag); alb[2] = 64'(s.ab);
			for (int k = 0; k < 3; k++) begin
				prod = (alb[k] * s16 * 64'(onb_pkg::INVPI_Q24)) >> 40;
				if (prod > 64'd65535) prod = 64'd65535;
				if (k == 0) r.vr = prod[15:0];
				else if (k == 1) r.vg = prod[15:0];
				else r.vb = prod[15:0];
			end
			prod = (cos_o * 64'(onb_pkg::INVPI_Q24)) >> 23;
			r.dens = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
			r.vres = 1'b1;
			return r;
		endfunction

		function void note_input(shade_t s);
			pending = {pending, evaluate(s)};
		endfunction

		function void check_result(brdf_t got);
			brdf_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word: %p", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d: expected %p, got %p", checked, exp_r, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	shade_t drv;
	brdf_t got;

	brdf_scoreboard brdf_sb;
	int idle_cycles = 0;
	bit quiet = 0;
	int words_sent = 0;

	oren_nayar_brdf_eval i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_dir_x(drv.ix), .in_dir_y(drv.iy), .in_dir_z(drv.iz),
		.out_dir_x(drv.ox), .out_dir_y(drv.oy), .out_dir_z(drv.oz),
		.roughness(drv.rough),
		.albedo_red(drv.ar), .albedo_green(drv.ag), .albedo_blue(drv.ab),
		.lane_active(drv.lane),
		.out_valid(out_valid), .out_stall(out_stall),
		.value_red(got.vr), .value_green(got.vg), .value_blue(got.vb),
		.density(got.dens), .valid_res(got.vres)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		brdf_sb = new();
	end

	// Output side: random stall bursts, result check at the rising edge.
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 14);
				out_stall = 1'b1;
				repeat (burst) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) brdf_sb.check_result(got);
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(shade_t s);
		drv <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		brdf_sb.note_input(s);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_gap();
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (brdf_sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_enable(bit en);
		drain();
		cfg_data <= en;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		brdf_sb.lobe_on = en;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] rnd_dir();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Mostly a plausible unit-ish geometry with positive cosines, some noise.
	function automatic shade_t rnd_word();
		shade_t s;
		{s.ix, s.iy} = $urandom();
		{s.ox, s.oy} = $urandom();
		s.iz = 16'($urandom_range(1, 32767));
		s.oz = 16'($urandom_range(1, 32767));
		if ($urandom_range(0, 9) == 0) begin
			s.iz = rnd_dir(); s.oz = rnd_dir(); s.ix = rnd_dir(); s.ox = rnd_dir();
		end
		if ($urandom_range(0, 3) == 0) begin
			s.ix = s.ix >>> 1; s.iy = s.iy >>> 1; s.ox = s.ox >>> 1; s.oy = s.oy >>> 1;
		end
		s.rough = 15'($urandom());
		s.ar = 16'($urandom()); s.ag = 16'($urandom()); s.ab = 16'($urandom());
		s.lane = ($urandom_range(0, 15) != 0);
		return s;
	endfunction

	function automatic shade_t mk(int ix, int iy, int iz, int ox, int oy, int oz,
			int r, int alb, bit lane);
		shade_t s;
		s.ix = 16'(ix); s.iy = 16'(iy); s.iz = 16'(iz);
		s.ox = 16'(ox); s.oy = 16'(oy); s.oz = 16'(oz);
		s.rough = 15'(r); s.ar = 16'(alb); s.ag = 16'(65535 - alb); s.ab = 16'(alb);
		s.lane = lane;
		return s;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		drv = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(mk(0, 0, 32767, 0, 0, 32767, 0, 65535, 1));
		send_word(mk(0, 0, 32767, 0, 0, 32767, 32767, 65535, 1));
		send_word(mk(23170, 0, 23170, 23170, 0, 23170, 32767, 65535, 1));
		send_word(mk(-23170, 0, 23170, 23170, 0, 23170, 16384, 40000, 1));
		send_word(mk(0, 28377, 16384, 0, 28377, 16384, 20000, 65535, 1));
		send_word(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 65535, 1));
		send_word(mk(-32768, -32768, 1, -32768, -32768, 1, 32767, 65535, 1));
		send_word(mk(1000, 0, 0, 1000, 0, 30000, 100, 30000, 1));
		send_word(mk(1000, 0, 30000, 1000, 0, 0, 100, 30000, 1));
		send_word(mk(0, 0, -32768, 0, 0, 30000, 100, 30000, 1));
		send_word(mk(0, 0, 30000, 0, 0, -1, 100, 30000, 1));
		send_word(mk(0, 0, 30000, 0, 0, 30000, 100, 30000, 0));
		send_word(mk(5000, 5000, 1, 5000, 5000, 32767, 32767, 0, 1));
		write_enable(1'b0);
		send_word(mk(0, 0, 32767, 0, 0, 32767, 16384, 65535, 1));
		send_word(rnd_word());
		write_enable(1'b1);
		send_word(mk(0, 0, 32767, 0, 0, 32767, 16384, 65535, 1));

		for (int n = 0; n < 1250; n++) begin
			if (n == 400 || n == 700) write_enable(n == 700);
			if (n == 550) drain();
			if (n == 1050) quiet = 1;
			send_gap();
			send_word(rnd_word());
		end

		drain();
		$display("Sent %0d shading words with random idling, diffuse lobe toggled;",
			words_sent);
		$display("%0d result words checked, %0d mismatching.",
			brdf_sb.checked, brdf_sb.mismatches);
		if (brdf_sb.mismatches == 0 && brdf_sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
